// File: hw/rtl/lipm_pkg.sv
// lipm_pkg: shared types and constants for the lagrange interpolation block
// used by lipm_mulmod, lipm_datapath, lipm_ctrl and lagrange_interpolation_mod_p
package lipm_pkg;

    localparam int VAL_W       = 8;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int MM_STEPS    = PROD_W;
    localparam int MM_CNT_W    = $clog2(MM_STEPS + 1);
    localparam int IDX_OUT_W   = 4;
    localparam logic [VAL_W-1:0] MOD_RESET = 8'd251;
    localparam logic [VAL_W-1:0] MOD_MIN   = 8'd2;

    // operand selection for the shared multiply-add-reduce unit
    typedef enum logic [2:0] {
        MM_RED,
        MM_DEN,
        MM_BAS,
        MM_SCALE,
        MM_ACC
    } mm_sel_t;

    // write data source for the basis memory
    typedef enum logic [1:0] {
        BW_ONE,
        BW_RDATA,
        BW_MM
    } bas_wsel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED_RD,
        S_RED_GO,
        S_RED_WT,
        S_BAS_INIT,
        S_BAS_XI,
        S_J_CHK,
        S_J_DEN,
        S_J_DWT,
        S_K_TOP,
        S_K_ISS,
        S_K_LO,
        S_K_WT,
        S_INV,
        S_INV_WT,
        S_SC_WT,
        S_AC_RD,
        S_AC_GO,
        S_AC_WT,
        S_OUT_RD,
        S_OUT_WT
    } state_t;

    typedef struct packed {
        logic      pt_we;
        logic      pt_re;
        logic      xr_we;
        logic      xr_re;
        logic      bas_we;
        logic      bas_re;
        logic      res_we;
        logic      res_re;
        logic      mm_start;
        mm_sel_t   mm_sel;
        logic      a_zero;
        logic      cur_load;
        logic      den_init;
        logic      lat_xi;
        logic      inv_start;
        bas_wsel_t bas_wsel;
    } lipm_cmd_t;

    typedef struct packed {
        logic mm_done;
        logic inv_done;
        logic inv_ok;
    } lipm_sts_t;

endpackage

// File: hw/rtl/lagrange_interpolation_mod_p.sv
// Lagrange interpolation modulo a configurable prime. Points are loaded one beat
// per cycle; the beat marked last_point starts the solve, after which the n
// coefficients come out lowest power first, last_coeff on the highest. During the
// solve in_ready is low. All multiplications run through one multiply-add-reduce unit
// that reduces one bit per cycle, and the modular inverse is a linear search over
// k = 1 .. modulus-1 per basis. Each coefficient is read from the result memory
// before its beat is shown, so coefficient beats do not come back to back.
// The modulus register may be written only while no solve is in flight.
module lagrange_interpolation_mod_p #(
    parameter int MAX_POINTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lipm_pkg::VAL_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lipm_pkg::VAL_W-1:0]     x_value,
    input  logic [lipm_pkg::VAL_W-1:0]     y_value,
    input  logic                           last_point,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lipm_pkg::IDX_OUT_W-1:0] coeff_index,
    output logic [lipm_pkg::VAL_W-1:0]     coeff_value,
    output logic                           last_coeff,
    output logic                           error
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    lipm_pkg::lipm_cmd_t cmd;
    lipm_pkg::lipm_sts_t sts;
    logic [IDX_W-1:0]    pt_waddr;
    logic [IDX_W-1:0]    pt_raddr;
    logic [IDX_W-1:0]    xr_waddr;
    logic [IDX_W-1:0]    xr_raddr;
    logic [IDX_W-1:0]    bas_waddr;
    logic [IDX_W-1:0]    bas_raddr;
    logic [IDX_W-1:0]    res_addr;

    lipm_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .last_point  (last_point),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .coeff_index (coeff_index),
        .last_coeff  (last_coeff),
        .error       (error),
        .sts         (sts),
        .cmd         (cmd),
        .pt_waddr    (pt_waddr),
        .pt_raddr    (pt_raddr),
        .xr_waddr    (xr_waddr),
        .xr_raddr    (xr_raddr),
        .bas_waddr   (bas_waddr),
        .bas_raddr   (bas_raddr),
        .res_addr    (res_addr)
    );

    lipm_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .x_value     (x_value),
        .y_value     (y_value),
        .cmd         (cmd),
        .pt_waddr    (pt_waddr),
        .pt_raddr    (pt_raddr),
        .xr_waddr    (xr_waddr),
        .xr_raddr    (xr_raddr),
        .bas_waddr   (bas_waddr),
        .bas_raddr   (bas_raddr),
        .res_addr    (res_addr),
        .sts         (sts),
        .coeff_value (coeff_value)
    );

endmodule

// File: hw/rtl/lipm_mulmod.sv
// lipm_mulmod: computes (a + b * c) mod m sequentially
// one multiply at start, then one restoring reduction bit per cycle; uses lipm_pkg
module lipm_mulmod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lipm_pkg::VAL_W-1:0] a,
    input  logic [lipm_pkg::VAL_W-1:0] b,
    input  logic [lipm_pkg::VAL_W-1:0] c,
    input  logic [lipm_pkg::VAL_W-1:0] m,
    output logic                       done,
    output logic [lipm_pkg::VAL_W-1:0] result
);

    logic [lipm_pkg::PROD_W-1:0]   p_reg;
    logic [lipm_pkg::VAL_W-1:0]    r_reg;
    logic [lipm_pkg::MM_CNT_W-1:0] cnt_reg;
    logic                          done_reg;
    logic [lipm_pkg::VAL_W:0]      shifted;
    logic [lipm_pkg::VAL_W:0]      reduced;

    // r stays below m, so one conditional subtract per bit
    always_comb
    begin
        shifted = {r_reg, p_reg[lipm_pkg::PROD_W-1]};
        reduced = (shifted >= {1'b0, m}) ? (shifted - {1'b0, m}) : shifted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == lipm_pkg::MM_CNT_W'(1));
            if (start)
                cnt_reg <= lipm_pkg::MM_CNT_W'(lipm_pkg::MM_STEPS);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg <= lipm_pkg::PROD_W'(a)
                     + lipm_pkg::PROD_W'(b) * lipm_pkg::PROD_W'(c);
            r_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            p_reg <= {p_reg[lipm_pkg::PROD_W-2:0], 1'b0};
            r_reg <= reduced[lipm_pkg::VAL_W-1:0];
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

// File: hw/rtl/lipm_datapath.sv
// lipm_datapath: point, reduced-x, basis and result memories, modulus register,
// modular arithmetic unit and inverse search; uses lipm_pkg and lipm_mulmod
module lipm_datapath #(
    parameter  int MAX_POINTS = 16,
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lipm_pkg::VAL_W-1:0] cfg_data,
    input  logic [lipm_pkg::VAL_W-1:0] x_value,
    input  logic [lipm_pkg::VAL_W-1:0] y_value,
    input  lipm_pkg::lipm_cmd_t        cmd,
    input  logic [IDX_W-1:0]           pt_waddr,
    input  logic [IDX_W-1:0]           pt_raddr,
    input  logic [IDX_W-1:0]           xr_waddr,
    input  logic [IDX_W-1:0]           xr_raddr,
    input  logic [IDX_W-1:0]           bas_waddr,
    input  logic [IDX_W-1:0]           bas_raddr,
    input  logic [IDX_W-1:0]           res_addr,
    output lipm_pkg::lipm_sts_t        sts,
    output logic [lipm_pkg::VAL_W-1:0] coeff_value
);

    localparam int W = lipm_pkg::VAL_W;

    logic [2*W-1:0] pt_mem [MAX_POINTS];
    logic [W-1:0]   xr_mem [MAX_POINTS];
    logic [W-1:0]   bas_mem [MAX_POINTS];
    logic [W-1:0]   res_mem [MAX_POINTS];

    logic [2*W-1:0] pt_rdata;
    logic [W-1:0]   xr_rdata;
    logic [W-1:0]   bas_rdata;
    logic [W-1:0]   res_rdata;

    logic [W-1:0]   mod_reg;
    logic [W-1:0]   m_eff;
    logic [W-1:0]   xi_reg;
    logic [W-1:0]   cur_reg;
    logic [W-1:0]   denom_reg;
    logic [W-1:0]   scale_reg;
    lipm_pkg::mm_sel_t sel_reg;

    logic [W-1:0]   neg;
    logic [W-1:0]   diff;
    logic [W-1:0]   mm_a;
    logic [W-1:0]   mm_b;
    logic [W-1:0]   mm_c;
    logic [W-1:0]   mm_res;
    logic           mm_done;
    logic [W-1:0]   bas_wdata;

    logic           inv_busy_reg;
    logic           inv_done_reg;
    logic           inv_ok_reg;
    logic [W-1:0]   inv_r_reg;
    logic [W-1:0]   inv_k_reg;
    logic [W:0]     inv_sum;
    logic [W-1:0]   inv_red;
    logic [W-1:0]   inv_val;

    assign m_eff = (mod_reg < lipm_pkg::MOD_MIN) ? lipm_pkg::MOD_MIN : mod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= lipm_pkg::MOD_RESET;
        else if (cfg_we)
            mod_reg <= cfg_data;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.pt_we)
            pt_mem[pt_waddr] <= {x_value, y_value};
        if (cmd.pt_re)
            pt_rdata <= pt_mem[pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.xr_we)
            xr_mem[xr_waddr] <= mm_res;
        if (cmd.xr_re)
            xr_rdata <= xr_mem[xr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bas_we)
            bas_mem[bas_waddr] <= bas_wdata;
        if (cmd.bas_re)
            bas_rdata <= bas_mem[bas_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_we)
            res_mem[res_addr] <= mm_res;
        if (cmd.res_re)
            res_rdata <= res_mem[res_addr];
    end

    always_comb
    begin
        case (cmd.bas_wsel)
            lipm_pkg::BW_ONE:   bas_wdata = W'(1);
            lipm_pkg::BW_RDATA: bas_wdata = bas_rdata;
            lipm_pkg::BW_MM:    bas_wdata = mm_res;
            default:            bas_wdata = mm_res;
        endcase
    end

    // xj sits in xr_rdata for the whole inner loop; both x values are reduced
    always_comb
    begin
        neg  = (xr_rdata == '0) ? '0 : (m_eff - xr_rdata);
        diff = (xi_reg >= xr_rdata) ? (xi_reg - xr_rdata)
                                    : W'({1'b0, xi_reg} + {1'b0, m_eff} - {1'b0, xr_rdata});
    end

    always_comb
    begin
        case (cmd.mm_sel)
            lipm_pkg::MM_RED:
            begin
                mm_a = '0;
                mm_b = pt_rdata[2*W-1:W];
                mm_c = W'(1);
            end
            lipm_pkg::MM_DEN:
            begin
                mm_a = '0;
                mm_b = denom_reg;
                mm_c = diff;
            end
            lipm_pkg::MM_BAS:
            begin
                mm_a = cmd.a_zero ? '0 : bas_rdata;
                mm_b = cur_reg;
                mm_c = neg;
            end
            lipm_pkg::MM_SCALE:
            begin
                mm_a = '0;
                mm_b = inv_val;
                mm_c = pt_rdata[W-1:0];
            end
            lipm_pkg::MM_ACC:
            begin
                mm_a = cmd.a_zero ? '0 : res_rdata;
                mm_b = bas_rdata;
                mm_c = scale_reg;
            end
            default:
            begin
                mm_a = '0;
                mm_b = '0;
                mm_c = '0;
            end
        endcase
    end

    lipm_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mm_start),
        .a      (mm_a),
        .b      (mm_b),
        .c      (mm_c),
        .m      (m_eff),
        .done   (mm_done),
        .result (mm_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.lat_xi)
            xi_reg <= xr_rdata;
        if (cmd.cur_load)
            cur_reg <= bas_rdata;
        else if (cmd.mm_start && cmd.mm_sel == lipm_pkg::MM_BAS)
            cur_reg <= mm_a;
        if (cmd.mm_start)
            sel_reg <= cmd.mm_sel;
        if (cmd.den_init)
            denom_reg <= W'(1);
        else if (mm_done && sel_reg == lipm_pkg::MM_DEN)
            denom_reg <= mm_res;
        if (mm_done && sel_reg == lipm_pkg::MM_SCALE)
            scale_reg <= mm_res;
    end

    // inverse search: walk r = d*k mod m upward until r hits one or k reaches m-1
    always_comb
    begin
        inv_sum = {1'b0, inv_r_reg} + {1'b0, denom_reg};
        inv_red = (inv_sum >= {1'b0, m_eff}) ? W'(inv_sum - {1'b0, m_eff}) : W'(inv_sum);
        inv_val = inv_ok_reg ? inv_k_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_busy_reg <= 1'b0;
            inv_done_reg <= 1'b0;
            inv_ok_reg   <= 1'b0;
        end
        else
        begin
            inv_done_reg <= 1'b0;
            if (cmd.inv_start)
            begin
                inv_busy_reg <= 1'b1;
                inv_ok_reg   <= 1'b0;
            end
            else if (inv_busy_reg)
            begin
                if (inv_r_reg == W'(1))
                begin
                    inv_busy_reg <= 1'b0;
                    inv_done_reg <= 1'b1;
                    inv_ok_reg   <= 1'b1;
                end
                else if (inv_k_reg == m_eff - W'(1))
                begin
                    inv_busy_reg <= 1'b0;
                    inv_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.inv_start)
        begin
            inv_r_reg <= denom_reg;
            inv_k_reg <= W'(1);
        end
        else if (inv_busy_reg && inv_r_reg != W'(1) && inv_k_reg != m_eff - W'(1))
        begin
            inv_r_reg <= inv_red;
            inv_k_reg <= inv_k_reg + W'(1);
        end
    end

    assign sts.mm_done  = mm_done;
    assign sts.inv_done = inv_done_reg;
    assign sts.inv_ok   = inv_ok_reg;
    assign coeff_value  = res_rdata;

endmodule

// File: hw/rtl/lipm_ctrl.sv
// lipm_ctrl: sequencer for point loading, interpolation loops and coefficient output
// drives lipm_datapath through lipm_pkg command and status structs
module lipm_ctrl #(
    parameter  int MAX_POINTS = 16,
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CNT_W      = $clog2(MAX_POINTS + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           last_point,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lipm_pkg::IDX_OUT_W-1:0] coeff_index,
    output logic                           last_coeff,
    output logic                           error,
    input  lipm_pkg::lipm_sts_t            sts,
    output lipm_pkg::lipm_cmd_t            cmd,
    output logic [IDX_W-1:0]               pt_waddr,
    output logic [IDX_W-1:0]               pt_raddr,
    output logic [IDX_W-1:0]               xr_waddr,
    output logic [IDX_W-1:0]               xr_raddr,
    output logic [IDX_W-1:0]               bas_waddr,
    output logic [IDX_W-1:0]               bas_raddr,
    output logic [IDX_W-1:0]               res_addr
);

    lipm_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             err_reg, err_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] deg_reg, deg_next;

    logic accept;
    logic room;
    logic k_last_out;

    assign accept     = in_valid && in_ready;
    assign room       = (cnt_reg < CNT_W'(MAX_POINTS));
    assign k_last_out = ((CNT_W'(k_reg) + CNT_W'(1)) == cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lipm_pkg::S_IDLE:
                if (accept && last_point)
                    state_next = lipm_pkg::S_RED_RD;
            lipm_pkg::S_RED_RD:   state_next = lipm_pkg::S_RED_GO;
            lipm_pkg::S_RED_GO:   state_next = lipm_pkg::S_RED_WT;
            lipm_pkg::S_RED_WT:
                if (sts.mm_done)
                    state_next = ((j_reg + CNT_W'(1)) == cnt_reg) ? lipm_pkg::S_BAS_INIT
                                                                  : lipm_pkg::S_RED_RD;
            lipm_pkg::S_BAS_INIT: state_next = lipm_pkg::S_BAS_XI;
            lipm_pkg::S_BAS_XI:   state_next = lipm_pkg::S_J_CHK;
            lipm_pkg::S_J_CHK:
                if (j_reg == cnt_reg)
                    state_next = lipm_pkg::S_INV;
                else if (j_reg != i_reg)
                    state_next = lipm_pkg::S_J_DEN;
            lipm_pkg::S_J_DEN:    state_next = lipm_pkg::S_J_DWT;
            lipm_pkg::S_J_DWT:
                if (sts.mm_done)
                    state_next = lipm_pkg::S_K_TOP;
            lipm_pkg::S_K_TOP:    state_next = lipm_pkg::S_K_ISS;
            lipm_pkg::S_K_ISS:    state_next = lipm_pkg::S_K_LO;
            lipm_pkg::S_K_LO:     state_next = lipm_pkg::S_K_WT;
            lipm_pkg::S_K_WT:
                if (sts.mm_done)
                    state_next = (k_reg == '0) ? lipm_pkg::S_J_CHK : lipm_pkg::S_K_ISS;
            lipm_pkg::S_INV:      state_next = lipm_pkg::S_INV_WT;
            lipm_pkg::S_INV_WT:
                if (sts.inv_done)
                    state_next = lipm_pkg::S_SC_WT;
            lipm_pkg::S_SC_WT:
                if (sts.mm_done)
                    state_next = lipm_pkg::S_AC_RD;
            lipm_pkg::S_AC_RD:    state_next = lipm_pkg::S_AC_GO;
            lipm_pkg::S_AC_GO:    state_next = lipm_pkg::S_AC_WT;
            lipm_pkg::S_AC_WT:
                if (sts.mm_done)
                begin
                    if (k_reg != deg_reg)
                        state_next = lipm_pkg::S_AC_RD;
                    else if ((i_reg + CNT_W'(1)) == cnt_reg)
                        state_next = lipm_pkg::S_OUT_RD;
                    else
                        state_next = lipm_pkg::S_BAS_INIT;
                end
            lipm_pkg::S_OUT_RD:   state_next = lipm_pkg::S_OUT_WT;
            lipm_pkg::S_OUT_WT:
                if (out_ready)
                    state_next = k_last_out ? lipm_pkg::S_IDLE : lipm_pkg::S_OUT_RD;
            default:              state_next = lipm_pkg::S_IDLE;
        endcase
    end

    // loop counters and flags
    always_comb
    begin
        cnt_next = cnt_reg;
        err_next = err_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        k_next   = k_reg;
        deg_next = deg_reg;
        case (state_reg)
            lipm_pkg::S_IDLE:
                if (accept)
                begin
                    if (room)
                        cnt_next = cnt_reg + CNT_W'(1);
                    else
                        err_next = 1'b1;
                    j_next = '0;
                end
            lipm_pkg::S_RED_WT:
                if (sts.mm_done)
                begin
                    j_next = j_reg + CNT_W'(1);
                    i_next = '0;
                end
            lipm_pkg::S_BAS_INIT:
            begin
                j_next   = '0;
                deg_next = '0;
            end
            lipm_pkg::S_J_CHK:
                if (j_reg != cnt_reg && j_reg == i_reg)
                    j_next = j_reg + CNT_W'(1);
            lipm_pkg::S_J_DWT:
                if (sts.mm_done)
                    k_next = deg_reg;
            lipm_pkg::S_K_WT:
                if (sts.mm_done)
                begin
                    if (k_reg == '0)
                    begin
                        deg_next = deg_reg + IDX_W'(1);
                        j_next   = j_reg + CNT_W'(1);
                    end
                    else
                        k_next = k_reg - IDX_W'(1);
                end
            lipm_pkg::S_INV_WT:
                if (sts.inv_done && !sts.inv_ok)
                    err_next = 1'b1;
            lipm_pkg::S_SC_WT:
                if (sts.mm_done)
                    k_next = '0;
            lipm_pkg::S_AC_WT:
                if (sts.mm_done)
                begin
                    if (k_reg != deg_reg)
                        k_next = k_reg + IDX_W'(1);
                    else
                    begin
                        i_next = i_reg + CNT_W'(1);
                        k_next = '0;
                    end
                end
            lipm_pkg::S_OUT_WT:
                if (out_ready)
                begin
                    if (k_last_out)
                    begin
                        cnt_next = '0;
                        err_next = 1'b0;
                    end
                    else
                        k_next = k_reg + IDX_W'(1);
                end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // datapath commands and handshake outputs
    always_comb
    begin
        cmd          = '0;
        cmd.mm_sel   = lipm_pkg::MM_RED;
        cmd.bas_wsel = lipm_pkg::BW_MM;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        case (state_reg)
            lipm_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.pt_we = in_valid && room;
            end
            lipm_pkg::S_RED_RD:
                cmd.pt_re = 1'b1;
            lipm_pkg::S_RED_GO:
                cmd.mm_start = 1'b1;
            lipm_pkg::S_RED_WT:
                cmd.xr_we = sts.mm_done;
            lipm_pkg::S_BAS_INIT:
            begin
                cmd.pt_re    = 1'b1;
                cmd.xr_re    = 1'b1;
                cmd.bas_we   = 1'b1;
                cmd.bas_wsel = lipm_pkg::BW_ONE;
                cmd.den_init = 1'b1;
            end
            lipm_pkg::S_BAS_XI:
                cmd.lat_xi = 1'b1;
            lipm_pkg::S_J_CHK:
                cmd.xr_re = (j_reg != cnt_reg) && (j_reg != i_reg);
            lipm_pkg::S_J_DEN:
            begin
                cmd.mm_start = 1'b1;
                cmd.mm_sel   = lipm_pkg::MM_DEN;
            end
            lipm_pkg::S_J_DWT:
            begin
                cmd.mm_sel = lipm_pkg::MM_DEN;
                cmd.bas_re = sts.mm_done;
            end
            lipm_pkg::S_K_TOP:
            begin
                // shift the top coefficient up one power
                cmd.bas_we   = 1'b1;
                cmd.bas_wsel = lipm_pkg::BW_RDATA;
                cmd.cur_load = 1'b1;
            end
            lipm_pkg::S_K_ISS:
                cmd.bas_re = (k_reg != '0);
            lipm_pkg::S_K_LO:
            begin
                cmd.mm_start = 1'b1;
                cmd.mm_sel   = lipm_pkg::MM_BAS;
                cmd.a_zero   = (k_reg == '0);
            end
            lipm_pkg::S_K_WT:
            begin
                cmd.mm_sel = lipm_pkg::MM_BAS;
                cmd.bas_we = sts.mm_done;
            end
            lipm_pkg::S_INV:
                cmd.inv_start = 1'b1;
            lipm_pkg::S_INV_WT:
            begin
                cmd.mm_start = sts.inv_done;
                cmd.mm_sel   = lipm_pkg::MM_SCALE;
            end
            lipm_pkg::S_AC_RD:
            begin
                cmd.bas_re = 1'b1;
                cmd.res_re = 1'b1;
            end
            lipm_pkg::S_AC_GO:
            begin
                // first basis overwrites, which clears stale results
                cmd.mm_start = 1'b1;
                cmd.mm_sel   = lipm_pkg::MM_ACC;
                cmd.a_zero   = (i_reg == '0);
            end
            lipm_pkg::S_AC_WT:
            begin
                cmd.mm_sel = lipm_pkg::MM_ACC;
                cmd.res_we = sts.mm_done;
            end
            lipm_pkg::S_OUT_RD:
                cmd.res_re = 1'b1;
            lipm_pkg::S_OUT_WT:
                out_valid = 1'b1;
            default:
                in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        pt_waddr  = cnt_reg[IDX_W-1:0];
        pt_raddr  = (state_reg == lipm_pkg::S_BAS_INIT) ? i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];
        xr_raddr  = pt_raddr;
        xr_waddr  = j_reg[IDX_W-1:0];
        res_addr  = k_reg;
        if (state_reg == lipm_pkg::S_K_ISS)
            bas_raddr = k_reg - IDX_W'(1);
        else if (state_reg == lipm_pkg::S_J_DWT)
            bas_raddr = deg_reg;
        else
            bas_raddr = k_reg;
        if (state_reg == lipm_pkg::S_K_TOP)
            bas_waddr = deg_reg + IDX_W'(1);
        else if (state_reg == lipm_pkg::S_BAS_INIT)
            bas_waddr = '0;
        else
            bas_waddr = k_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lipm_pkg::S_IDLE;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            deg_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            deg_reg   <= deg_next;
        end
    end

    assign coeff_index = lipm_pkg::IDX_OUT_W'(k_reg);
    assign last_coeff  = k_last_out;
    assign error       = err_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");

    a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cnt_reg != '0) && (CNT_W'(k_reg) < cnt_reg))
        else $error("coefficient beat outside the loaded point set");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(k_reg) && $stable(err_reg))
        else $error("stalled coefficient beat changed");

    a_solve_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_coeff) |=> (cnt_reg == '0) && !err_reg && in_ready)
        else $error("state not cleared after final coefficient");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lipm_pkg::S_AC_WT) |-> (k_reg <= deg_reg))
        else $error("accumulate index beyond basis degree");

endmodule

// File: bench/tb_lagrange_interpolation_mod_p.sv
// testbench for lagrange_interpolation_mod_p: random and directed point sets,
// coefficients checked against an in-bench interpolation predictor
// depends on lipm_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_lagrange_interpolation_mod_p;

    localparam int NPTS = 16;
    localparam int CYC_LIMIT = 20000000;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic       last;
    } point_t;

    typedef struct packed {
        logic [3:0] idx;
        logic [7:0] val;
        logic       lst;
        logic       err;
    } coeff_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [7:0] cfg_data = 8'd0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] x_value = 8'd0;
    logic [7:0] y_value = 8'd0;
    logic last_point = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [3:0] coeff_index;
    logic [7:0] coeff_value;
    logic last_coeff;
    logic error;

    point_t pending_pts[$];
    coeff_t coeffs_due[$];
    int     fail_count = 0;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     sets_done = 0;

    // predictor state
    int         pmod = 251;
    logic [7:0] px[NPTS];
    logic [7:0] py[NPTS];
    int         pcount = 0;
    bit         perr = 1'b0;

    lagrange_interpolation_mod_p #(.MAX_POINTS(NPTS)) i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .x_value(x_value),
        .y_value(y_value), .last_point(last_point), .out_valid(out_valid),
        .out_ready(out_ready), .coeff_index(coeff_index),
        .coeff_value(coeff_value), .last_coeff(last_coeff), .error(error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    function automatic int inv_mod(input int d, input int m, output bit ok);
        ok = 1'b0;
        for (int k = 1; k < m; k++)
            if ((d * k) % m == 1)
            begin
                ok = 1'b1;
                return k;
            end
        return 0;
    endfunction

    // interpolate the stored points and queue the coefficients
    task automatic interpolate_points();
        int m;
        int res[NPTS];
        int bas[NPTS+1];
        int xi, xj, neg, den, deg, inv, sc;
        bit ok;
        coeff_t c;
        m = (pmod < 2) ? 2 : pmod;
        foreach (res[k]) res[k] = 0;
        for (int i = 0; i < pcount; i++)
        begin
            xi = px[i] % m;
            den = 1 % m;
            foreach (bas[k]) bas[k] = 0;
            bas[0] = 1 % m;
            deg = 0;
            for (int j = 0; j < pcount; j++)
            begin
                if (j == i) continue;
                xj = px[j] % m;
                neg = (m - xj) % m;
                den = (den * ((xi + m - xj) % m)) % m;
                bas[deg+1] = bas[deg];
                for (int k = deg; k > 0; k--)
                    bas[k] = (bas[k-1] + bas[k] * neg) % m;
                bas[0] = (bas[0] * neg) % m;
                deg++;
            end
            inv = inv_mod(den, m, ok);
            if (!ok) perr = 1'b1;
            sc = (inv * (py[i] % m)) % m;
            for (int k = 0; k <= deg && k < NPTS; k++)
                res[k] = (res[k] + bas[k] * sc) % m;
        end
        for (int k = 0; k < pcount; k++)
        begin
            c.idx = k[3:0];
            c.val = res[k][7:0];
            c.lst = (k + 1 == pcount);
            c.err = perr;
            coeffs_due.push_back(c);
        end
        pcount = 0;
        perr = 1'b0;
    endtask

    task automatic predict_point(input point_t p);
        if (pcount < NPTS)
        begin
            px[pcount] = p.x;
            py[pcount] = p.y;
            pcount++;
        end
        else
            perr = 1'b1;
        if (p.last) interpolate_points();
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    point_t p;
                    p = pending_pts.pop_front();
                    in_valid <= 1'b1;
                    x_value <= p.x;
                    y_value <= p.y;
                    last_point <= p.last;
                    predict_point(p);
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (coeffs_due.size() == 0)
                report("unexpected beat, index", coeff_index, -1);
            else
            begin
                coeff_t c;
                c = coeffs_due.pop_front();
                if (coeff_index !== c.idx) report("coeff_index", coeff_index, c.idx);
                if (coeff_value !== c.val) report("coeff_value", coeff_value, c.val);
                if (last_coeff !== c.lst) report("last_coeff", last_coeff, c.lst);
                if (error !== c.err) report("error", error, c.err);
            end
        end
        if (cycle_count > CYC_LIMIT)
        begin
            $display("timeout");
            $display("FAIL");
            $finish;
        end
    end

    // queue one set of n points with distinct x modulo m as far as m allows, optionally broken
    task automatic queue_set(input int n, input int m, input bit dup);
        bit used[256];
        point_t p;
        int xv;
        foreach (used[k]) used[k] = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            do xv = $urandom_range(255);
            while (used[xv % m] && !dup && i < m);
            used[xv % m] = 1'b1;
            p.x = xv[7:0];
            p.y = $urandom_range(255);
            p.last = (i == n - 1);
            pending_pts.push_back(p);
        end
    endtask

    task automatic drain();
        while (pending_pts.size() > 0 || in_valid || coeffs_due.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_modulus(input int m);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= m[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        pmod = m;
    endtask

    task automatic queue_pt(input int xv, input int yv, input bit l);
        point_t p;
        p.x = xv[7:0];
        p.y = yv[7:0];
        p.last = l;
        pending_pts.push_back(p);
    endtask

    initial
    begin
        int mods[8];
        int n;
        mods = '{251, 2, 255, 7, 13, 0, 97, 251};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: single point, extremes, duplicate x, overflow
        queue_pt(255, 255, 1'b1);
        queue_pt(0, 0, 1'b0);
        queue_pt(250, 255, 1'b1);
        queue_pt(5, 1, 1'b0);
        queue_pt(5, 2, 1'b1);
        queue_pt(1, 255, 1'b0);
        queue_pt(252, 3, 1'b1);
        for (int i = 0; i < 18; i++)
            queue_pt(i * 13, 255 - i, i == 17);
        drain();

        foreach (mods[q])
        begin
            send_idle_pct = (q % 4 == 1 || q % 4 == 3) ? 80 : 0;
            recv_stall_pct = (q % 4 == 2 || q % 4 == 3) ? 80 : 0;
            if (q % 4 == 3)
            begin
                send_idle_pct = 11;
                recv_stall_pct = 11;
            end
            set_modulus(mods[q]);
            for (int s = 0; s < 7; s++)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(14, 17)
                                             : $urandom_range(1, 5);
                queue_set(n, (mods[q] < 2) ? 2 : mods[q], $urandom_range(7) == 0);
            end
            drain();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
